// ===== rtl/core/hqp_pkg.sv =====
// package for the quadratic-probe hash table
// field widths, action and status codes, controller/datapath command and status structs
// no dependencies
package hqp_pkg;

    localparam int KEY_W          = 16;
    localparam int HANDLE_W       = 16;
    localparam int COUNT_W        = 9;
    localparam int HASH_W         = KEY_W + 4;
    localparam int TABLE_SIZE_DEF = 256;

    localparam logic [3:0]         HASH_MUL  = 4'd13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    // bit positions in the slot flag word
    localparam int FLAG_USED = 0;
    localparam int FLAG_DEL  = 1;
    localparam int FLAG_W    = 2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic hash_step;
        logic load_home;
        logic advance;
        logic wr_insert;
        logic wr_remove;
        logic take_handle;
        logic res_ok;
        logic res_full;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic       clear_last;
        logic       act_known;
        logic       hash_done;
        logic       slot_free;
        logic       slot_match;
        logic       probe_last;
        logic       out_free;
        logic [1:0] action;
    } t_dp_stat;

endpackage

// ===== rtl/core/hqp_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module hqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hqp_datapath.sv =====
// datapath: hash reduction, probe sequence, slot memories, result and output registers
// depends on hqp_pkg and hqp_ram
module hqp_datapath #(
    parameter int TABLE_SIZE = hqp_pkg::TABLE_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hqp_pkg::t_dp_cmd               i_cmd,
    output hqp_pkg::t_dp_stat              o_stat,
    input  logic [1:0]                     i_action,
    input  logic [hqp_pkg::KEY_W-1:0]      i_key,
    input  logic [hqp_pkg::HANDLE_W-1:0]   i_handle,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [1:0]                     o_status,
    output logic [hqp_pkg::HANDLE_W-1:0]   o_found_handle,
    output logic [hqp_pkg::COUNT_W-1:0]    o_entry_count
);
    import hqp_pkg::*;

    localparam int IDX_W    = $clog2(TABLE_SIZE);
    localparam bit IS_POW2  = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
    localparam int HCNT_W   = $clog2(HASH_W + 1);
    localparam int ODD_INIT = 3 % TABLE_SIZE;
    localparam int DATA_W   = KEY_W + HANDLE_W;

    localparam logic [IDX_W:0]    SIZE_EXT  = (IDX_W + 1)'(TABLE_SIZE);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
    localparam logic [HCNT_W-1:0] HASH_STEPS = HCNT_W'(HASH_W);

    logic [1:0]          r_action;
    logic [KEY_W-1:0]    r_key;
    logic [HANDLE_W-1:0] r_handle;
    logic [HASH_W-1:0]   r_prod;
    logic [IDX_W-1:0]    r_rem;
    logic [HCNT_W-1:0]   r_hcnt;
    logic [IDX_W-1:0]    r_slot;
    logic [IDX_W-1:0]    r_sq;
    logic [IDX_W-1:0]    r_odd;
    logic [IDX_W:0]      r_probe;
    t_status             r_res_status;
    logic [HANDLE_W-1:0] r_res_found;
    logic [COUNT_W-1:0]  r_count;
    logic [IDX_W-1:0]    r_clr_addr;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [HANDLE_W-1:0] r_out_found;
    logic [COUNT_W-1:0]  r_out_count;

    logic [IDX_W-1:0]  n_rem;
    logic [IDX_W-1:0]  n_slot;
    logic [IDX_W-1:0]  n_sq;
    logic [IDX_W-1:0]  n_odd;
    logic [IDX_W:0]    rem_sum;
    logic [IDX_W:0]    slot_sum;
    logic [IDX_W:0]    sq_sum;
    logic [IDX_W:0]    odd_sum;

    logic              data_we;
    logic [DATA_W-1:0] data_rdata;
    logic              flag_we;
    logic [IDX_W-1:0]  flag_waddr;
    logic [FLAG_W-1:0] flag_wdata;
    logic [FLAG_W-1:0] flag_rdata;
    logic [KEY_W-1:0]  rd_key;
    logic [HANDLE_W-1:0] rd_handle;

    // one remainder bit per step for sizes that are not a power of two
    always_comb begin
        rem_sum  = {r_rem, r_prod[HASH_W-1]};
        n_rem    = (rem_sum >= SIZE_EXT) ? IDX_W'(rem_sum - SIZE_EXT) : rem_sum[IDX_W-1:0];
        slot_sum = {1'b0, r_slot} + {1'b0, r_sq};
        n_slot   = (slot_sum >= SIZE_EXT) ? IDX_W'(slot_sum - SIZE_EXT) : slot_sum[IDX_W-1:0];
        sq_sum   = {1'b0, r_sq} + {1'b0, r_odd};
        n_sq     = (sq_sum >= SIZE_EXT) ? IDX_W'(sq_sum - SIZE_EXT) : sq_sum[IDX_W-1:0];
        odd_sum  = {1'b0, r_odd} + (IDX_W + 1)'(2);
        n_odd    = (odd_sum >= SIZE_EXT) ? IDX_W'(odd_sum - SIZE_EXT) : odd_sum[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action     <= i_action;
            r_key        <= i_key;
            r_handle     <= i_handle;
            r_prod       <= HASH_W'(i_key) * HASH_W'(HASH_MUL);
            r_rem        <= '0;
            r_hcnt       <= '0;
            r_res_status <= ST_NOT_FOUND;
            r_res_found  <= '0;
        end
        if (i_cmd.hash_step) begin
            r_rem  <= n_rem;
            r_prod <= {r_prod[HASH_W-2:0], 1'b0};
            r_hcnt <= r_hcnt + HCNT_W'(1);
        end
        if (i_cmd.load_home) begin
            r_slot  <= IS_POW2 ? r_prod[IDX_W-1:0] : r_rem;
            r_sq    <= IDX_W'(1);
            r_odd   <= IDX_W'(ODD_INIT);
            r_probe <= (IDX_W + 1)'(1);
        end
        if (i_cmd.advance) begin
            r_slot  <= n_slot;
            r_sq    <= n_sq;
            r_odd   <= n_odd;
            r_probe <= r_probe + (IDX_W + 1)'(1);
        end
        if (i_cmd.res_ok) begin
            r_res_status <= ST_OK;
        end
        if (i_cmd.res_full) begin
            r_res_status <= ST_FULL;
        end
        if (i_cmd.take_handle) begin
            r_res_found <= rd_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
            r_out_status <= ST_OK;
            r_out_found  <= '0;
            r_out_count  <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cmd.wr_insert && r_count != COUNT_MAX) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_res_status;
                r_out_found  <= r_res_found;
                r_out_count  <= r_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // key and handle store, no reset
    assign data_we = i_cmd.wr_insert;

    hqp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_SIZE)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (r_slot),
        .i_wdata ({r_key, r_handle}),
        .i_raddr (r_slot),
        .o_rdata (data_rdata)
    );

    // used and deleted flags, swept to zero after reset
    always_comb begin
        flag_we    = i_cmd.clear_step | i_cmd.wr_insert | i_cmd.wr_remove;
        flag_waddr = i_cmd.clear_step ? r_clr_addr : r_slot;
        flag_wdata = '0;
        if (i_cmd.wr_insert) begin
            flag_wdata[FLAG_USED] = 1'b1;
        end
        if (i_cmd.wr_remove) begin
            flag_wdata[FLAG_USED] = 1'b1;
            flag_wdata[FLAG_DEL]  = 1'b1;
        end
    end

    hqp_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (TABLE_SIZE)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_raddr (r_slot),
        .o_rdata (flag_rdata)
    );

    assign rd_key    = data_rdata[DATA_W-1:HANDLE_W];
    assign rd_handle = data_rdata[HANDLE_W-1:0];

    always_comb begin
        o_stat.clear_last = (r_clr_addr == LAST_IDX);
        o_stat.act_known  = r_action inside {ACT_INSERT, ACT_REMOVE, ACT_SEARCH};
        o_stat.hash_done  = IS_POW2 ? 1'b1 : (r_hcnt == HASH_STEPS);
        o_stat.slot_free  = !flag_rdata[FLAG_USED];
        o_stat.slot_match = flag_rdata[FLAG_USED] && !flag_rdata[FLAG_DEL] && (rd_key == r_key);
        o_stat.probe_last = (r_probe == SIZE_EXT);
        o_stat.out_free   = !r_out_valid || i_out_ready;
        o_stat.action     = r_action;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found_handle = r_out_found;
    assign o_entry_count  = r_out_count;

endmodule

// ===== rtl/core/hqp_ctrl.sv =====
// controller state machine for the quadratic-probe hash table
// depends on hqp_pkg
module hqp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  hqp_pkg::t_dp_stat  i_stat,
    output hqp_pkg::t_dp_cmd   o_cmd
);
    import hqp_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_READ  = 6'b001000,
        S_EVAL  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_HASH;
                end
            end
            S_HASH: begin
                if (!i_stat.act_known) begin
                    n_state = S_DONE;
                end else if (i_stat.hash_done) begin
                    o_cmd.load_home = 1'b1;
                    n_state         = S_READ;
                end else begin
                    o_cmd.hash_step = 1'b1;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_stat.action == ACT_INSERT) begin
                    if (i_stat.slot_free) begin
                        o_cmd.wr_insert = 1'b1;
                        o_cmd.res_ok    = 1'b1;
                        n_state         = S_DONE;
                    end else if (i_stat.probe_last) begin
                        o_cmd.res_full = 1'b1;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_READ;
                    end
                end else begin
                    if (i_stat.slot_free) begin
                        n_state = S_DONE;
                    end else if (i_stat.slot_match) begin
                        o_cmd.wr_remove   = (i_stat.action == ACT_REMOVE);
                        o_cmd.take_handle = (i_stat.action == ACT_SEARCH);
                        o_cmd.res_ok      = 1'b1;
                        n_state           = S_DONE;
                    end else if (i_stat.probe_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/core/hash_table_quadratic_probe_top.sv =====
// top level of the quadratic-probe hash table of key and record-handle pairs
// depends on hqp_pkg, hqp_ctrl, hqp_datapath (which holds two hqp_ram instances)

// Open-addressed table of TABLE_SIZE slots. Each item is an insert, remove or
// search on a 16-bit key; every item gives exactly one result item. The home
// slot is key*13 mod TABLE_SIZE and probe i moves the slot on by i*i, mod
// TABLE_SIZE, for at most TABLE_SIZE slots. Insert takes the first slot never
// used (deleted slots are not reused) and reports table full otherwise;
// remove marks the first live match deleted; search returns its handle.
// entry_count counts inserts and saturates at 511. After reset the block
// sweeps the used/deleted flag memory and takes no item until the sweep
// ends. An item then needs one memory read and one compare per slot probed,
// through the registered read port of the slot memories. For a TABLE_SIZE
// that is not a power of two the home slot is reduced one bit a cycle. The
// next item is taken while a result still waits on the output.
module hash_table_quadratic_probe_top #(
    parameter int TABLE_SIZE = hqp_pkg::TABLE_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_action,
    input  logic [hqp_pkg::KEY_W-1:0]      i_lookup_key,
    input  logic [hqp_pkg::HANDLE_W-1:0]   i_record_handle,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_status,
    output logic [hqp_pkg::HANDLE_W-1:0]   o_found_handle,
    output logic [hqp_pkg::COUNT_W-1:0]    o_entry_count
);
    import hqp_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing: clear sweep, hash, probe read/compare loop, result handoff
    hqp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // slot memories, probe arithmetic and the output register
    hqp_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_action       (i_action),
        .i_key          (i_lookup_key),
        .i_handle       (i_record_handle),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_status       (o_status),
        .o_found_handle (o_found_handle),
        .o_entry_count  (o_entry_count)
    );

`ifndef SYNTHESIS
    // one item in flight: the request side closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while an item was in flight");

    // a handle is only returned with a successful status
    a_handle_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found_handle != '0) |-> (o_status == ST_OK))
        else $error("nonzero handle with a failing status");

    // the insert count shown on the output never goes down
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_entry_count >= $past(o_entry_count)))
        else $error("entry count decreased");
`endif

endmodule
